>>> design/jsec_pkg.sv
// Shared types, constants and helpers for the JSON string escaper.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package jsec_pkg;

  // Input item kinds
  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;

  // Control bytes with a short escape
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  // Command queue geometry (depth must be a power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // What the back end has to emit for one item
  typedef enum logic [1:0] {
    CMD_ONE  = 2'd0,  // one byte as it is
    CMD_ESC2 = 2'd1,  // backslash, then the byte
    CMD_HEX  = 2'd2,  // backslash u 0 0 hi lo
    CMD_ERR  = 2'd3   // single error result
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

  // Index of the final output byte for a command
  function automatic logic [2:0] cmd_last_idx(input cmd_kind_t kind);
    logic [2:0] r;
    case (kind)
      CMD_ESC2: r = 3'd1;
      CMD_HEX:  r = 3'd5;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/jsec_front.sv
// Front end: accepts items, tracks UTF-8 and sticky error state, classifies.
// Depends on jsec_pkg.
`timescale 1ns / 1ps

module jsec_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [1:0]    func,
  input  logic [7:0]    data_byte,
  output logic          push,
  output jsec_pkg::cmd_t cmd
);
  import jsec_pkg::*;

  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       error_sticky;
  logic       error_sticky_next;
  logic       emit;
  logic       raise;

  always_comb begin
    pending_next = pending;
    error_sticky_next = error_sticky;
    emit = 1'b0;
    raise = 1'b0;
    cmd.kind = CMD_ONE;
    cmd.value = CH_QUOTE;
    if (!error_sticky) begin
      case (func)
        FUNC_BEGIN: begin
          emit = 1'b1;
          pending_next = 2'd0;
        end
        FUNC_END: begin
          emit = 1'b1;
          if (pending != 2'd0) begin
            raise = 1'b1;
          end
        end
        FUNC_DATA: begin
          emit = 1'b1;
          cmd.value = data_byte;
          if (pending != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
              raise = 1'b1;
            end else begin
              pending_next = pending - 2'd1;
            end
          end else if (data_byte == BYTE_BS) begin
            cmd.kind = CMD_ESC2;
            cmd.value = CH_B;
          end else if (data_byte == BYTE_FF) begin
            cmd.kind = CMD_ESC2;
            cmd.value = CH_F;
          end else if (data_byte == BYTE_LF) begin
            cmd.kind = CMD_ESC2;
            cmd.value = CH_N;
          end else if (data_byte == BYTE_CR) begin
            cmd.kind = CMD_ESC2;
            cmd.value = CH_R;
          end else if (data_byte == BYTE_TAB) begin
            cmd.kind = CMD_ESC2;
            cmd.value = CH_T;
          end else if (data_byte == CH_QUOTE || data_byte == CH_BSLASH) begin
            cmd.kind = CMD_ESC2;
          end else if (data_byte <= 8'h1F) begin
            cmd.kind = CMD_HEX;
          end else if (data_byte <= 8'h7F) begin
            cmd.kind = CMD_ONE;
          end else if (data_byte[7:5] == 3'b110) begin
            pending_next = 2'd1;
          end else if (data_byte[7:4] == 4'b1110) begin
            pending_next = 2'd2;
          end else if (data_byte[7:3] == 5'b11110) begin
            pending_next = 2'd3;
          end else begin
            raise = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (raise) begin
        cmd.kind = CMD_ERR;
        cmd.value = 8'd0;
        pending_next = 2'd0;
        error_sticky_next = 1'b1;
      end
    end
  end

  assign push = in_fire && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      error_sticky <= 1'b0;
    end else if (in_fire) begin
      pending <= pending_next;
      error_sticky <= error_sticky_next;
    end
  end

  a_no_push_when_sticky: assert property (@(posedge clk) disable iff (rst)
    error_sticky |-> !push)
    else $error("front pushed a command after a sticky error");

  a_err_sets_sticky: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.kind == CMD_ERR) |=> (error_sticky && pending == 2'd0))
    else $error("error command did not set sticky error");

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    $past(error_sticky) && !$past(rst) |-> error_sticky)
    else $error("sticky error cleared without reset");

endmodule

>>> design/jsec_queue.sv
// Short command queue between the front and back ends.
// Depends on jsec_pkg for the command type and depth.
`timescale 1ns / 1ps

module jsec_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jsec_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output jsec_pkg::cmd_t head
);
  import jsec_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

>>> design/jsec_back.sv
// Back end: expands queued commands into output bytes through an output register.
// Depends on jsec_pkg.
`timescale 1ns / 1ps

module jsec_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  jsec_pkg::cmd_t cmd,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic           m_tuser
);
  import jsec_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       at_last;
  logic [7:0] ch;

  assign load = cmd_valid && (!m_tvalid || m_tready);
  assign at_last = (idx == cmd_last_idx(cmd.kind));
  assign pop = load && at_last;

  always_comb begin
    ch = cmd.value;
    case (cmd.kind)
      CMD_ESC2: begin
        if (idx == 3'd0) begin
          ch = CH_BSLASH;
        end
      end
      CMD_HEX: begin
        case (idx)
          3'd0: ch = CH_BSLASH;
          3'd1: ch = CH_U;
          3'd2: ch = CH_ZERO;
          3'd3: ch = CH_ZERO;
          3'd4: ch = hex_digit(cmd.value[7:4]);
          default: ch = hex_digit(cmd.value[3:0]);
        endcase
      end
      CMD_ERR: ch = 8'd0;
      default: ch = cmd.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx <= 3'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx <= at_last ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= ch;
      m_tlast <= at_last;
      m_tuser <= (cmd.kind == CMD_ERR);
    end
  end

  a_idx_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    (idx != 3'd0) |-> cmd_valid)
    else $error("expansion in progress with no queued command");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> idx <= cmd_last_idx(cmd.kind))
    else $error("byte index past end of command");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
    else $error("error result not a single zero byte");

endmodule

>>> design/json_string_escaper_utf8_check_unit.sv
// JSON string escaper with UTF-8 check: one stream of begin/data/end items in,
// escaped JSON text bytes out, through the front end, the command queue and the
// output register. Throughput is one item per cycle for items that give one byte
// while the output is not stalled; the back-end expander paces the escapes,
// which give two or six bytes. Reset (rst, synchronous) clears UTF-8 and error
// state, the command queue and the output register.
`timescale 1ns / 1ps

module json_string_escaper_utf8_check_unit (
  input  logic       clk,
  input  logic       rst,
  // Input items
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [1:0] func
  // Escaped text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_of_run
  output logic       m_tuser    // [0] utf8_error
);
  import jsec_pkg::*;

  logic in_fire;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic full;
  logic not_empty;
  cmd_t head;

  // Take an item whenever the queue has room; items that give no output
  // are simply absorbed by the front end.
  assign s_tready = !full;
  assign in_fire = s_tvalid && s_tready;

  // Classify the item and update UTF-8 / sticky-error state
  jsec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .func      (s_tuser),
    .data_byte (s_tdata),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Decouple classification from expansion
  jsec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // Expand each command into one to six output bytes
  jsec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (not_empty),
    .cmd       (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

>>> tb/sv/jsec_text_checker.sv
// Scoreboard for the JSON string escaper: predicts the escaped text of every
// accepted input transaction and checks each output transaction against it.
// Depends on jsec_pkg for the item kinds and character codes.
`timescale 1ns / 1ps

module jsec_text_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [1:0] func
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic       m_tlast,   // last_of_run
  input  logic       m_tuser,   // [0] utf8_error
  output int         n_expected,
  output int         n_mismatch
);
  import jsec_pkg::*;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } text_beat_t;

  text_beat_t awaited_text[$];
  logic [1:0] cont_left = 2'd0;
  logic       utf8_bad = 1'b0;

  initial begin
    n_expected = 0;
    n_mismatch = 0;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return CH_LOWER_A + {4'd0, nib} - 8'd10;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (n_mismatch < PRINT_CAP) begin
      $display("%0t ns checker: %s: got %h, want %h", $time, what, got, want);
    end
    n_mismatch++;
  endtask

  // Work out the text that one input item turns into and queue it.
  task automatic escape_item(input logic [1:0] kind, input logic [7:0] b);
    logic [7:0] seq [6];
    int n;
    bit fault;
    n = 0;
    fault = 1'b0;
    if (utf8_bad) begin
      return;
    end
    case (kind)
      FUNC_BEGIN: begin
        cont_left = 2'd0;
        seq[0] = CH_QUOTE;
        n = 1;
      end
      FUNC_END: begin
        if (cont_left != 2'd0) begin
          fault = 1'b1;
        end else begin
          seq[0] = CH_QUOTE;
          n = 1;
        end
      end
      FUNC_DATA: begin
        if (cont_left != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            fault = 1'b1;
          end else begin
            cont_left = cont_left - 2'd1;
            seq[0] = b;
            n = 1;
          end
        end else begin
          seq[0] = CH_BSLASH;
          case (b)
            BYTE_BS:  begin seq[1] = CH_B; n = 2; end
            BYTE_FF:  begin seq[1] = CH_F; n = 2; end
            BYTE_LF:  begin seq[1] = CH_N; n = 2; end
            BYTE_CR:  begin seq[1] = CH_R; n = 2; end
            BYTE_TAB: begin seq[1] = CH_T; n = 2; end
            CH_QUOTE, CH_BSLASH: begin
              seq[1] = b;
              n = 2;
            end
            default: begin
              if (b <= 8'h1F) begin
                seq[1] = CH_U;
                seq[2] = CH_ZERO;
                seq[3] = CH_ZERO;
                seq[4] = hex_char(b[7:4]);
                seq[5] = hex_char(b[3:0]);
                n = 6;
              end else if (b <= 8'h7F) begin
                seq[0] = b;
                n = 1;
              end else if (b[7:5] == 3'b110) begin
                cont_left = 2'd1;
                seq[0] = b;
                n = 1;
              end else if (b[7:4] == 4'b1110) begin
                cont_left = 2'd2;
                seq[0] = b;
                n = 1;
              end else if (b[7:3] == 5'b11110) begin
                cont_left = 2'd3;
                seq[0] = b;
                n = 1;
              end else begin
                fault = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    if (fault) begin
      utf8_bad = 1'b1;
      cont_left = 2'd0;
      awaited_text.push_back('{ch: 8'h00, last: 1'b1, err: 1'b1});
    end else begin
      for (int k = 0; k < n; k++) begin
        awaited_text.push_back('{ch: seq[k], last: (k == n - 1), err: 1'b0});
      end
    end
  endtask

  task automatic check_beat();
    text_beat_t want;
    if (awaited_text.size() == 0) begin
      report_mismatch("output transaction with nothing expected", m_tdata, 8'h00);
      return;
    end
    want = awaited_text.pop_front();
    if (m_tdata !== want.ch) begin
      report_mismatch("out_byte", m_tdata, want.ch);
    end
    if (m_tlast !== want.last) begin
      report_mismatch("last_of_run", {7'd0, m_tlast}, {7'd0, want.last});
    end
    if (m_tuser !== want.err) begin
      report_mismatch("utf8_error", {7'd0, m_tuser}, {7'd0, want.err});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_text.delete();
      cont_left = 2'd0;
      utf8_bad = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        escape_item(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        check_beat();
      end
    end
    n_expected <= awaited_text.size();
  end

endmodule

>>> tb/sv/json_string_escaper_utf8_check_unit_test.sv
// Top of the JSON string escaper test: clock, reset, stimulus, back-pressure
// and the verdict. Depends on jsec_pkg, the block and jsec_text_checker.
`timescale 1ns / 1ps

module json_string_escaper_utf8_check_unit_test;
  import jsec_pkg::*;

  // Kind code that the block has to ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 8;
  localparam int TOTAL_ITEMS  = 270;   // counts only items the block acts on
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 10;   // extra wait after the predicted text has drained
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction at all

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0] s_tuser = 2'd0;    // [1:0] func
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // last_of_run
  logic       m_tuser;           // [0] utf8_error

  int n_expected;
  int n_mismatch;

  // Sender state
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int items_sent = 0;

  // Receiver state; hold_asked is bumped by the stimulus to request a hold-off
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int ready_phase = 0;

  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_escaper_utf8_check_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  jsec_text_checker text_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .n_expected (n_expected),
    .n_mismatch (n_mismatch)
  );

  // Receiver: hold a random stall pattern for a random stretch, then pick another.
  // A requested hold-off takes priority and drops tready until hold_left runs out.
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 90);
      end
      mode_left--;
      ready_phase++;
      case (ready_mode)
        0: m_tready <= 1'b1;                              // no stalls at all
        1: m_tready <= 1'($urandom_range(0, 1));          // coin flip
        2: m_tready <= ($urandom_range(0, 3) == 0);       // mostly stalled
        default: m_tready <= ((ready_phase % 3) != 0);    // fixed rhythm
      endcase
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("json_string_escaper_utf8_check_unit_test: done, errors");
      $finish;
    end
  end

  // Offer one item and hold it until the transaction completes. A new burst
  // may start with a gap with tvalid low. Called just after a rising edge.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    bit took;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
      end
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= b;
    // Sample tready mid-cycle, where it has settled for the coming edge
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    if (kind != FUNC_UNUSED) begin
      items_sent++;
    end
  endtask

  // Drop tvalid and wait until every predicted byte has come out, then wait out
  // the settle time as well in case the last items caused nothing.
  task automatic drain_text();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (n_expected != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send one UTF-8 character with random payload bits. When cut is set, send only
  // some of the continuation bytes, never the last, so that bytes are still pending.
  task automatic send_utf8_char(input int len, input bit cut);
    logic [7:0] lead;
    int keep;
    case (len)
      2: lead = {3'b110, 5'($urandom)};
      3: lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    keep = cut ? $urandom_range(0, len - 2) : len - 1;
    send_item(FUNC_DATA, lead);
    for (int i = 0; i < keep; i++) begin
      send_item(FUNC_DATA, {2'b10, 6'($urandom)});
    end
  endtask

  // One well-formed string with random content, spiced with ignored kinds,
  // restarts in the middle of a character and stray bytes after the end.
  task automatic send_random_string();
    int len;
    int pick;
    bit cut;
    send_item(FUNC_BEGIN, 8'($urandom));
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(FUNC_DATA, 8'($urandom_range(8'h20, 8'h7F)));
      end else if (pick < 55) begin
        send_item(FUNC_DATA, 8'($urandom_range(8'h00, 8'h1F)));
      end else if (pick < 62) begin
        send_item(FUNC_DATA, $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
      end else if (pick < 65) begin
        send_item(FUNC_UNUSED, 8'($urandom));
      end else begin
        cut = ($urandom_range(0, 19) == 0);
        send_utf8_char($urandom_range(2, 4), cut);
        if (cut) begin
          send_item(FUNC_BEGIN, 8'($urandom));
        end
      end
    end
    send_item(FUNC_END, 8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      send_item(FUNC_DATA, 8'($urandom_range(8'h20, 8'h7F)));
    end
  endtask

  initial begin
    bit held;
    bit drained;
    logic [7:0] bad;
    int len;
    held = 1'b0;
    drained = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every escape class, the ends of the byte ranges, full and cut
    // UTF-8 characters, a restart mid-character, an ignored kind and a byte
    // sent outside any string.
    send_item(FUNC_BEGIN, 8'hFF);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, BYTE_BS);
    send_item(FUNC_DATA, BYTE_TAB);
    send_item(FUNC_DATA, BYTE_LF);
    send_item(FUNC_DATA, BYTE_FF);
    send_item(FUNC_DATA, BYTE_CR);
    send_item(FUNC_DATA, 8'h1F);
    send_item(FUNC_DATA, CH_QUOTE);
    send_item(FUNC_DATA, CH_BSLASH);
    send_item(FUNC_DATA, 8'h20);
    send_item(FUNC_DATA, 8'h7F);
    send_item(FUNC_DATA, 8'hC3);
    send_item(FUNC_DATA, 8'hA9);
    send_item(FUNC_DATA, 8'hE2);
    send_item(FUNC_DATA, 8'h82);
    send_item(FUNC_DATA, 8'hAC);
    send_item(FUNC_DATA, 8'hF0);
    send_item(FUNC_DATA, 8'h9F);
    send_item(FUNC_DATA, 8'h98);
    send_item(FUNC_DATA, 8'hBF);
    send_item(FUNC_DATA, 8'hF4);
    send_item(FUNC_BEGIN, 8'h00);
    send_item(FUNC_END, 8'hAA);
    send_item(FUNC_UNUSED, 8'h55);
    send_item(FUNC_DATA, 8'h41);

    // Random strings until the item budget is used up
    while (items_sent < TOTAL_ITEMS) begin
      if (!held && items_sent >= 60) begin
        // Stall the receiver for a long stretch while offering more input
        hold_asked <= hold_asked + 1;
        held = 1'b1;
      end
      if (!drained && items_sent >= 140) begin
        drain_text();
        drained = 1'b1;
      end
      // Run a stretch with no sender gaps
      gaps_on = !(items_sent >= 170 && items_sent < 220);
      send_random_string();
    end

    // Finish with one malformed sequence; the error then swallows the rest.
    send_item(FUNC_BEGIN, 8'($urandom));
    send_item(FUNC_DATA, 8'($urandom_range(8'h20, 8'h7F)));
    len = $urandom_range(2, 4);
    case ($urandom_range(0, 2))
      0: begin
        // Lead byte that no UTF-8 character starts with
        bad = $urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
        send_item(FUNC_DATA, bad);
      end
      1: begin
        // Continuation slot filled with a byte that is not 10xxxxxx
        send_utf8_char(len, 1'b1);
        bad = 8'($urandom);
        if (bad[7:6] == 2'b10) begin
          bad[7:6] = $urandom_range(0, 1) ? 2'b11 : 2'b00;
        end
        send_item(FUNC_DATA, bad);
      end
      default: begin
        // End of string with continuation bytes still owed
        send_utf8_char(len, 1'b1);
        send_item(FUNC_END, 8'($urandom));
      end
    endcase
    send_item(FUNC_BEGIN, 8'($urandom));
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, 8'($urandom));
    send_item(FUNC_END, 8'($urandom));

    drain_text();
    if (n_mismatch == 0) begin
      $display("json_string_escaper_utf8_check_unit_test: done, clean");
    end else begin
      $display("json_string_escaper_utf8_check_unit_test: done, errors");
    end
    $finish;
  end

endmodule
